// ===== sv/cbt_pkg.sv =====
// Shared types, constants and helpers for the colour blob centroid tracker.
// No dependencies; every other file of the tracker imports this package.
package cbt_pkg;

    // Largest frame the tracker is built for.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // Pixel counters index up to MAX_DIM - 1; window coordinates can reach
    // twice that after a re-centre, so they carry one bit more.
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;

    localparam int CHAN_W     = 8;
    localparam int THR_W      = 7;
    localparam int CFG_DIM_W  = 12;
    localparam int OUT_W      = 12;
    localparam int HIT_W      = 23;
    localparam int SUM_W      = 34;
    localparam int HALF_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Width for window arithmetic that mixes frame sizes and twice the half-size.
    localparam int CMP_W = ((DIM_W > HALF_W + 1) ? DIM_W : HALF_W + 1) + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
    localparam logic [HALF_W-1:0] HALF_MIN  = 8'd40;
    localparam logic [HALF_W-1:0] HALF_MAX  = 8'd200;
    localparam logic [HALF_W-1:0] HALF_STEP = 8'd10;

    localparam logic [THR_W-1:0]     THR_RESET    = 7'd20;
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 12'd480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    // Accumulated totals of one frame, handed from the front to the back.
    typedef struct packed {
        logic [HIT_W-1:0] hits;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
    } t_job;

    // Search window as the front sees it; the ends are kept precomputed.
    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W:0]   x_end;
        logic [DIM_W:0]   y_end;
    } t_window;

    typedef struct packed {
        logic take;
        logic done;
    } t_back_stat;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } t_result;

    // Frame size in use: zero counts as one, and it is limited to the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v,
                                                 input int unsigned maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > maxv) begin
            res = DIM_W'(maxv);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== sv/cbt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the centroid divisions.
// Depends on cbt_pkg for the sum and count widths.
module cbt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cbt_pkg::SUM_W-1:0] i_dividend,
    input  logic [cbt_pkg::HIT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [cbt_pkg::SUM_W-1:0] o_quot
);
    import cbt_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [HIT_W-1:0]  r_rem;
    logic [HIT_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_q;

    logic [HIT_W:0]    shifted;
    logic [HIT_W:0]    diff;
    logic              ge;

    // The dividend shifts out of the top of r_q while quotient bits shift in.
    assign shifted = {r_rem, r_q[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[HIT_W-1:0] : shifted[HIT_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/cbt_rq.sv =====
// Two-entry result queue between the back end and the result port.
// Depends on cbt_pkg for the result type.
module cbt_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbt_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output cbt_pkg::t_result o_data
);
    import cbt_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd];

endmodule

// ===== sv/cbt_front.sv =====
// Pixel front end: raster counters, window and colour test, hit accumulators.
// Depends on cbt_pkg; hands each frame's totals to cbt_back.
module cbt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_busy,
    input  logic [cbt_pkg::CHAN_W-1:0] i_hue,
    input  logic [cbt_pkg::CHAN_W-1:0] i_sat,
    input  logic [cbt_pkg::CHAN_W-1:0] i_val,
    input  logic                       i_frame_end,
    input  logic [cbt_pkg::CHAN_W-1:0] i_hue_target,
    input  logic [cbt_pkg::CHAN_W-1:0] i_sat_target,
    input  logic [cbt_pkg::CHAN_W-1:0] i_val_target,
    input  logic [cbt_pkg::THR_W-1:0]  i_threshold,
    input  logic [cbt_pkg::DIM_W-1:0]  i_ew,
    input  logic [cbt_pkg::DIM_W-1:0]  i_eh,
    input  cbt_pkg::t_window           i_win,
    input  cbt_pkg::t_back_stat        i_stat,
    output cbt_pkg::t_job              o_job,
    output logic                       o_job_valid
);
    import cbt_pkg::*;

    function automatic logic [CHAN_W-1:0] chan_lo(input logic [CHAN_W-1:0] t,
                                                  input logic [THR_W-1:0]  thr);
        logic [CHAN_W-1:0] thr_x;
        thr_x = CHAN_W'(thr);
        return (t > thr_x) ? t - thr_x : '0;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_hi(input logic [CHAN_W-1:0] t,
                                                  input logic [THR_W-1:0]  thr);
        logic [CHAN_W:0] s;
        s = {1'b0, t} + (CHAN_W + 1)'(thr);
        return (s > {1'b0, CHAN_MAX}) ? CHAN_MAX : s[CHAN_W-1:0];
    endfunction

    logic [CHAN_W-1:0] tgt [3];
    logic [CHAN_W-1:0] pix [3];
    logic [CHAN_W-1:0] lo [3];
    logic [CHAN_W-1:0] hi [3];

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [HIT_W-1:0] r_hits;
    logic [SUM_W-1:0] r_sum_x;
    logic [SUM_W-1:0] r_sum_y;
    logic             r_busy;
    logic             r_job_valid;
    t_job             r_job;

    logic             accept;
    logic             colour_ok;
    logic             in_win;
    logic             hit;
    logic [DIM_W-1:0] dx;
    logic [DIM_W-1:0] dy;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;
    logic [HIT_W-1:0] n_hits;
    logic [SUM_W-1:0] n_sum_x;
    logic [SUM_W-1:0] n_sum_y;

    assign tgt[0] = i_hue_target;
    assign tgt[1] = i_sat_target;
    assign tgt[2] = i_val_target;
    assign pix[0] = i_hue;
    assign pix[1] = i_sat;
    assign pix[2] = i_val;

    // Channel bounds around each target, clipped to the channel range.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo[i] = chan_lo(tgt[i], i_threshold);
            hi[i] = chan_hi(tgt[i], i_threshold);
        end
    end

    always_comb begin
        colour_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (pix[i] < lo[i] || pix[i] > hi[i]) begin
                colour_ok = 1'b0;
            end
        end
    end

    assign in_win = ({1'b0, r_col} >= i_win.x) && ({2'b0, r_col} < i_win.x_end) &&
                    ({1'b0, r_row} >= i_win.y) && ({2'b0, r_row} < i_win.y_end);
    assign hit    = in_win && colour_ok;
    assign accept = i_push && !r_busy;

    assign dx      = {1'b0, r_col} - i_win.x;
    assign dy      = {1'b0, r_row} - i_win.y;
    assign n_hits  = hit ? r_hits + HIT_W'(1) : r_hits;
    assign n_sum_x = hit ? r_sum_x + SUM_W'(dx[CNT_W-1:0]) : r_sum_x;
    assign n_sum_y = hit ? r_sum_y + SUM_W'(dy[CNT_W-1:0]) : r_sum_y;

    assign col_next = {1'b0, r_col} + DIM_W'(1);
    assign row_next = {1'b0, r_row} + DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_hits      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_busy      <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_stat.take) begin
                r_job_valid <= 1'b0;
            end
            if (i_stat.done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                if (i_frame_end) begin
                    // The input stays closed until the back end has moved the window.
                    r_col       <= '0;
                    r_row       <= '0;
                    r_hits      <= '0;
                    r_sum_x     <= '0;
                    r_sum_y     <= '0;
                    r_busy      <= 1'b1;
                    r_job_valid <= 1'b1;
                end else begin
                    r_hits  <= n_hits;
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    if (col_next >= i_ew) begin
                        r_col <= '0;
                        // Without a frame end the last line keeps accumulating.
                        if (row_next < i_eh) begin
                            r_row <= row_next[CNT_W-1:0];
                        end
                    end else begin
                        r_col <= col_next[CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_frame_end) begin
            r_job.hits  <= n_hits;
            r_job.sum_x <= n_sum_x;
            r_job.sum_y <= n_sum_y;
        end
    end

    assign o_busy      = r_busy;
    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

endmodule

// ===== sv/cbt_back.sv =====
// Frame back end: centroid divisions, find decision, window update, result.
// Depends on cbt_pkg and cbt_div; feeds cbt_rq and the window used by cbt_front.
module cbt_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbt_pkg::t_job             i_job,
    input  logic                      i_job_valid,
    input  logic [cbt_pkg::DIM_W-1:0] i_ew,
    input  logic [cbt_pkg::DIM_W-1:0] i_eh,
    output cbt_pkg::t_back_stat       o_stat,
    output cbt_pkg::t_window          o_win,
    output logic                      o_rq_push,
    output cbt_pkg::t_result          o_rq_data,
    input  logic                      i_rq_full
);
    import cbt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_WIN,
        S_PUSH
    } t_state;

    t_state           r_state;
    t_job             r_job;
    logic [SUM_W-1:0] r_rx;
    logic             r_found;
    logic [DIM_W-1:0] r_cx;
    logic [DIM_W-1:0] r_cy;
    logic [DIM_W-1:0] r_wx;
    logic [DIM_W-1:0] r_wy;
    logic [DIM_W-1:0] r_x;
    logic [DIM_W-1:0] r_y;
    logic [DIM_W-1:0] r_w;
    logic [DIM_W-1:0] r_h;
    logic [DIM_W:0]   r_x_end;
    logic [DIM_W:0]   r_y_end;
    logic [HALF_W-1:0] r_half;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quot;
    logic [SUM_W-1:0] div_dividend;
    logic [HIT_W-1:0] div_divisor;

    logic             take;
    logic             done;
    logic             found;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [CMP_W-1:0] half_c;
    logic [CMP_W-1:0] two_half;
    logic [CMP_W-1:0] wx_c;
    logic [CMP_W-1:0] wy_c;
    logic [CMP_W-1:0] ew_c;
    logic [CMP_W-1:0] eh_c;
    logic [CMP_W-1:0] room_x;
    logic [CMP_W-1:0] room_y;
    logic [CMP_W-1:0] reach_x;
    logic [CMP_W-1:0] reach_y;
    logic [CMP_W-1:0] new_w;
    logic [CMP_W-1:0] new_h;
    logic [CMP_W-1:0] new_x_end;
    logic [CMP_W-1:0] new_y_end;

    assign take = (r_state == S_IDLE) && i_job_valid;
    assign done = (r_state == S_PUSH) && !i_rq_full;

    // The x division starts on the new job, the y division as soon as x is out.
    assign div_start    = take || ((r_state == S_DIVX) && div_done);
    assign div_dividend = (r_state == S_IDLE) ? i_job.sum_x : r_job.sum_y;
    assign div_divisor  = (r_state == S_IDLE) ? i_job.hits  : r_job.hits;

    cbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // A centroid on the window's first row or column does not count as found.
    assign found = (r_job.hits != '0) &&
                   (r_rx != '0) && (r_rx < SUM_W'(i_ew)) &&
                   (div_quot != '0) && (div_quot < SUM_W'(i_eh));
    assign cx = {1'b0, r_rx[CNT_W-1:0]} + r_x;
    assign cy = {1'b0, div_quot[CNT_W-1:0]} + r_y;

    assign half_c   = CMP_W'(r_half);
    assign two_half = CMP_W'({r_half, 1'b0});
    assign wx_c     = CMP_W'(r_wx);
    assign wy_c     = CMP_W'(r_wy);
    assign ew_c     = CMP_W'(i_ew);
    assign eh_c     = CMP_W'(i_eh);
    assign room_x   = ew_c - wx_c;
    assign room_y   = eh_c - wy_c;
    assign reach_x  = wx_c + two_half;
    assign reach_y  = wy_c + two_half;

    always_comb begin
        if (wx_c < ew_c) begin
            new_w     = (room_x > two_half) ? two_half : room_x;
            new_x_end = (reach_x > ew_c) ? ew_c : reach_x;
        end else begin
            new_w     = '0;
            new_x_end = wx_c;
        end
        if (wy_c < eh_c) begin
            new_h     = (room_y > two_half) ? two_half : room_y;
            new_y_end = (reach_y > eh_c) ? eh_c : reach_y;
        end else begin
            new_h     = '0;
            new_y_end = wy_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= '0;
            r_y     <= '0;
            r_w     <= eff_dim(WIDTH_RESET, MAX_WIDTH);
            r_h     <= eff_dim(HEIGHT_RESET, MAX_HEIGHT);
            r_x_end <= {1'b0, eff_dim(WIDTH_RESET, MAX_WIDTH)};
            r_y_end <= {1'b0, eff_dim(HEIGHT_RESET, MAX_HEIGHT)};
            r_half  <= HALF_MAX;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_job   <= i_job;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_rx    <= div_quot;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_found <= found;
                        r_cx    <= found ? cx : '0;
                        r_cy    <= found ? cy : '0;
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_wx    <= (CMP_W'(r_cx) > half_c) ? DIM_W'(CMP_W'(r_cx) - half_c) : '0;
                    r_wy    <= (CMP_W'(r_cy) > half_c) ? DIM_W'(CMP_W'(r_cy) - half_c) : '0;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_rq_full) begin
                        if (r_found) begin
                            r_x     <= r_wx;
                            r_y     <= r_wy;
                            r_w     <= DIM_W'(new_w);
                            r_h     <= DIM_W'(new_h);
                            r_x_end <= (DIM_W + 1)'(new_x_end);
                            r_y_end <= (DIM_W + 1)'(new_y_end);
                            if (r_half > HALF_MIN) begin
                                r_half <= r_half - HALF_STEP;
                            end
                        end else begin
                            r_x     <= '0;
                            r_y     <= '0;
                            r_w     <= i_ew;
                            r_h     <= i_eh;
                            r_x_end <= {1'b0, i_ew};
                            r_y_end <= {1'b0, i_eh};
                            if (r_half < HALF_MAX) begin
                                r_half <= r_half + HALF_STEP;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.take  = take;
    assign o_stat.done  = done;
    assign o_win.x      = r_x;
    assign o_win.y      = r_y;
    assign o_win.x_end  = r_x_end;
    assign o_win.y_end  = r_y_end;
    assign o_rq_push    = done;
    assign o_rq_data.found = r_found;
    assign o_rq_data.x     = OUT_W'(r_cx);
    assign o_rq_data.y     = OUT_W'(r_cy);

    ast_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half >= HALF_MIN && r_half <= HALF_MAX)
        else $error("window half-size left its range");

    ast_window_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_end == {1'b0, r_x} + {1'b0, r_w} && r_y_end == {1'b0, r_y} + {1'b0, r_h})
        else $error("window end does not match corner plus size");

    ast_job_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_state == S_DIVX)
        else $error("pending frame job was not started");

    ast_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_state == S_IDLE && !div_done)
        else $error("back end not idle after the window update");

endmodule

// ===== sv/color_blob_centroid_tracker.sv =====
// A pixel without frame_end is taken while full is low, at one pixel per cycle.
// After a frame_end pixel, full stays high through a hand-over of the frame's
// totals, two serial divisions and the window update, and longer while the
// two-entry result queue is full; the result is queued at the end of that time.
// Reset is synchronous and active low; it restores the register defaults and a
// full-frame search window with the largest half-size.
module color_blob_centroid_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [cbt_pkg::CHAN_W-1:0]     i_hue,
    input  logic [cbt_pkg::CHAN_W-1:0]     i_sat,
    input  logic [cbt_pkg::CHAN_W-1:0]     i_val,
    input  logic                           i_frame_end,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_found,
    output logic [cbt_pkg::OUT_W-1:0]      o_blob_x,
    output logic [cbt_pkg::OUT_W-1:0]      o_blob_y,
    input  logic                           i_cfg_we,
    input  logic [cbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cbt_pkg::*;

    logic [CHAN_W-1:0]    r_hue_target;
    logic [CHAN_W-1:0]    r_sat_target;
    logic [CHAN_W-1:0]    r_val_target;
    logic [THR_W-1:0]     r_threshold;
    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;

    logic [DIM_W-1:0] ew;
    logic [DIM_W-1:0] eh;
    t_window          win;
    t_back_stat       stat;
    t_job             job;
    logic             job_valid;
    logic             rq_push;
    logic             rq_full;
    t_result          rq_in;
    t_result          rq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_target <= '0;
            r_sat_target <= '0;
            r_val_target <= '0;
            r_threshold  <= THR_RESET;
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUE:    r_hue_target <= i_cfg_data[CHAN_W-1:0];
                CFG_SAT:    r_sat_target <= i_cfg_data[CHAN_W-1:0];
                CFG_VAL:    r_val_target <= i_cfg_data[CHAN_W-1:0];
                CFG_THR:    r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_WIDTH:  r_width      <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT: r_height     <= i_cfg_data[CFG_DIM_W-1:0];
                default:    r_width      <= r_width;
            endcase
        end
    end

    assign ew = eff_dim(r_width, MAX_WIDTH);
    assign eh = eff_dim(r_height, MAX_HEIGHT);

    cbt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_busy       (full),
        .i_hue        (i_hue),
        .i_sat        (i_sat),
        .i_val        (i_val),
        .i_frame_end  (i_frame_end),
        .i_hue_target (r_hue_target),
        .i_sat_target (r_sat_target),
        .i_val_target (r_val_target),
        .i_threshold  (r_threshold),
        .i_ew         (ew),
        .i_eh         (eh),
        .i_win        (win),
        .i_stat       (stat),
        .o_job        (job),
        .o_job_valid  (job_valid)
    );

    cbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .i_ew        (ew),
        .i_eh        (eh),
        .o_stat      (stat),
        .o_win       (win),
        .o_rq_push   (rq_push),
        .o_rq_data   (rq_in),
        .i_rq_full   (rq_full)
    );

    cbt_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rq_out)
    );

    assign o_found  = rq_out.found;
    assign o_blob_x = rq_out.x;
    assign o_blob_y = rq_out.y;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for color_blob_centroid_tracker: streams HSV frames in raster
// order, predicts each frame's centroid in a scoreboard class and checks every result.
// Depends on cbt_pkg and the color_blob_centroid_tracker module.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbt_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    // Tracks the colour thresholds, window and accumulators as the block should.
    class blob_scoreboard;
        logic [CHAN_W-1:0]    hue_t, sat_t, val_t;
        logic [THR_W-1:0]     thr;
        logic [CFG_DIM_W-1:0] cfg_w, cfg_h;
        int unsigned          col, row;
        logic [HIT_W-1:0]     hits;
        logic [SUM_W-1:0]     sum_x, sum_y;
        int unsigned          win_x, win_y, win_w, win_h, half;
        t_result              pending_q[$];
        int unsigned          errors, pixels, frames, finds;

        function new();
            errors = 0;
            pixels = 0;
            frames = 0;
            finds  = 0;
            restore_defaults();
        endfunction

        function void restore_defaults();
            hue_t = '0;
            sat_t = '0;
            val_t = '0;
            thr   = THR_RESET;
            cfg_w = WIDTH_RESET;
            cfg_h = HEIGHT_RESET;
            col   = 0;
            row   = 0;
            hits  = '0;
            sum_x = '0;
            sum_y = '0;
            win_x = 0;
            win_y = 0;
            win_w = 32'(WIDTH_RESET);
            win_h = 32'(HEIGHT_RESET);
            half  = 32'(HALF_MAX);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HUE:    hue_t = data[CHAN_W-1:0];
                CFG_SAT:    sat_t = data[CHAN_W-1:0];
                CFG_VAL:    val_t = data[CHAN_W-1:0];
                CFG_THR:    thr   = data[THR_W-1:0];
                CFG_WIDTH:  cfg_w = data[CFG_DIM_W-1:0];
                CFG_HEIGHT: cfg_h = data[CFG_DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned limit_dim(logic [CFG_DIM_W-1:0] v, int unsigned top);
            if (v == '0)
                return 1;
            if (32'(v) > top)
                return top;
            return 32'(v);
        endfunction

        // Accepted channel range around a target, clipped to 0..255.
        function void band(input logic [CHAN_W-1:0] t, output int unsigned lo,
                           output int unsigned hi);
            lo = (32'(t) > 32'(thr)) ? 32'(t) - 32'(thr) : 0;
            hi = 32'(t) + 32'(thr);
            if (hi > 255)
                hi = 255;
        endfunction

        function bit in_band(logic [CHAN_W-1:0] p, logic [CHAN_W-1:0] t);
            int unsigned lo, hi;
            band(t, lo, hi);
            return 32'(p) >= lo && 32'(p) <= hi;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t ns mismatch: %s", $time, msg);
        endfunction

        function void note_pixel(logic [CHAN_W-1:0] h, logic [CHAN_W-1:0] s,
                                 logic [CHAN_W-1:0] v, logic last);
            int unsigned     ew, eh;
            longint unsigned rx, ry, cx, cy, wx, wy, ww, wh;
            bit              in_win;
            t_result         r;
            ew = limit_dim(cfg_w, MAX_WIDTH);
            eh = limit_dim(cfg_h, MAX_HEIGHT);
            pixels++;
            in_win = col >= win_x && col < win_x + win_w && row >= win_y && row < win_y + win_h;
            if (in_win && in_band(h, hue_t) && in_band(s, sat_t) && in_band(v, val_t)) begin
                hits  = hits + 1'b1;
                sum_x = sum_x + SUM_W'(col - win_x);
                sum_y = sum_y + SUM_W'(row - win_y);
            end
            // The row stops at the last line, so a frame that overruns keeps
            // accumulating there.
            if (col + 1 >= ew) begin
                col = 0;
                if (row + 1 < eh)
                    row++;
            end else begin
                col++;
            end
            if (!last)
                return;

            r  = '0;
            cx = 0;
            cy = 0;
            if (hits != '0) begin
                rx = 64'(sum_x) / 64'(hits);
                ry = 64'(sum_y) / 64'(hits);
                // A centroid on the window's first row or column is not a find.
                if (rx > 0 && rx < 64'(ew) && ry > 0 && ry < 64'(eh)) begin
                    r.found = 1'b1;
                    cx = rx + 64'(win_x);
                    cy = ry + 64'(win_y);
                end
            end
            if (r.found) begin
                wx = (cx > 64'(half)) ? cx - 64'(half) : 0;
                wy = (cy > 64'(half)) ? cy - 64'(half) : 0;
                ww = (wx < 64'(ew)) ? 64'(ew) - wx : 0;
                wh = (wy < 64'(eh)) ? 64'(eh) - wy : 0;
                if (ww > 64'(2 * half))
                    ww = 64'(2 * half);
                if (wh > 64'(2 * half))
                    wh = 64'(2 * half);
                win_x = 32'(wx);
                win_y = 32'(wy);
                win_w = 32'(ww);
                win_h = 32'(wh);
                if (half > 32'(HALF_MIN))
                    half -= 32'(HALF_STEP);
                finds++;
            end else begin
                if (half < 32'(HALF_MAX))
                    half += 32'(HALF_STEP);
                win_x = 0;
                win_y = 0;
                win_w = ew;
                win_h = eh;
            end
            r.x = cx[OUT_W-1:0];
            r.y = cy[OUT_W-1:0];
            pending_q = {pending_q, r};
            frames++;
            col   = 0;
            row   = 0;
            hits  = '0;
            sum_x = '0;
            sum_y = '0;
        endfunction

        function void check_result(logic found, logic [OUT_W-1:0] x, logic [OUT_W-1:0] y);
            t_result want;
            if (pending_q.size() == 0) begin
                flag($sformatf("result with none expected: found %0d x %0d y %0d",
                               found, x, y));
                return;
            end
            want = pending_q.pop_front();
            if (found !== want.found || x !== want.x || y !== want.y)
                flag($sformatf("expected found %0d x %0d y %0d, got found %0d x %0d y %0d",
                               want.found, want.x, want.y, found, x, y));
        endfunction

        function void close_out();
            if (pending_q.size() != 0)
                flag($sformatf("%0d frame results never arrived", pending_q.size()));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAN_W-1:0]     i_hue = '0;
    logic [CHAN_W-1:0]     i_sat = '0;
    logic [CHAN_W-1:0]     i_val = '0;
    logic                  i_frame_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_found;
    logic [OUT_W-1:0]      o_blob_x;
    logic [OUT_W-1:0]      o_blob_y;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    blob_scoreboard board;
    int unsigned    send_gap = 0;
    int unsigned    recv_stall = 0;
    int unsigned    settings = 0;
    int unsigned    rand_pixels;

    color_blob_centroid_tracker dut (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk)
        pop <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk)
        if (i_rst_n && pop && !empty)
            board.check_result(o_found, o_blob_x, o_blob_y);

    initial begin
        #5ms;
        $display("FAIL color_blob_centroid_tracker");
        $finish;
    end

    function automatic void set_idle(t_idle mode);
        case (mode)
            IDLE_SENDER:   begin send_gap = 79; recv_stall = 0;  end
            IDLE_RECEIVER: begin send_gap = 0;  recv_stall = 79; end
            IDLE_BOTH:     begin send_gap = 6;  recv_stall = 6;  end
            default:       begin send_gap = 0;  recv_stall = 0;  end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input logic [CHAN_W-1:0] h, input logic [CHAN_W-1:0] s,
                              input logic [CHAN_W-1:0] v, input logic last);
        while ($urandom_range(99) < send_gap) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_hue       <= h;
        i_sat       <= s;
        i_val       <= v;
        i_frame_end <= last;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        board.note_pixel(h, s, v, last);
        @(negedge i_clk);
    endtask

    // Holds the pixel stream until every frame result has been taken.
    task automatic wait_results();
        push <= 1'b0;
        while (board.pending_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        board.set_reg(idx, CFG_DATA_W'(data));
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned hue, input int unsigned sat,
                             input int unsigned val, input int unsigned thr,
                             input int unsigned w, input int unsigned h);
        write_reg(CFG_HUE, hue);
        write_reg(CFG_SAT, sat);
        write_reg(CFG_VAL, val);
        write_reg(CFG_THR, thr);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CHAN_W-1:0] chan_inside(logic [CHAN_W-1:0] t);
        int unsigned lo, hi;
        board.band(t, lo, hi);
        case ($urandom_range(3))
            0:       return CHAN_W'(lo);
            1:       return CHAN_W'(hi);
            2:       return t;
            default: return CHAN_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Just outside the accepted range where there is room, else anything.
    function automatic logic [CHAN_W-1:0] chan_outside(logic [CHAN_W-1:0] t);
        int unsigned lo, hi;
        board.band(t, lo, hi);
        if (lo > 0 && (hi == 255 || $urandom_range(1) == 0))
            return CHAN_W'(lo - 1);
        if (hi < 255)
            return CHAN_W'(hi + 1);
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic int unsigned pick_target();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 30)
            return 255;
        return $urandom_range(255);
    endfunction

    function automatic int unsigned pick_thr();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 20)
            return 120;
        return $urandom_range(120);
    endfunction

    // One frame of len pixels over a w x h raster with a rectangular blob of the
    // target colour, some near misses and random background.
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned len);
        int unsigned       x0, x1, y0, y1, x, y, p, kind;
        logic [CHAN_W-1:0] hv, sv, vv;
        x0 = $urandom_range(w - 1);
        x1 = $urandom_range(w - 1, x0);
        y0 = $urandom_range(h - 1);
        y1 = $urandom_range(h - 1, y0);
        for (p = 0; p < len; p++) begin
            x = p % w;
            y = p / w;
            if (y > h - 1)
                y = h - 1;
            kind = $urandom_range(99);
            if (x >= x0 && x <= x1 && y >= y0 && y <= y1 && kind < 85) begin
                hv = chan_inside(board.hue_t);
                sv = chan_inside(board.sat_t);
                vv = chan_inside(board.val_t);
            end else if (kind < 15) begin
                hv = chan_inside(board.hue_t);
                sv = chan_inside(board.sat_t);
                vv = chan_inside(board.val_t);
                case ($urandom_range(2))
                    0:       hv = chan_outside(board.hue_t);
                    1:       sv = chan_outside(board.sat_t);
                    default: vv = chan_outside(board.val_t);
                endcase
            end else begin
                hv = CHAN_W'($urandom_range(255));
                sv = CHAN_W'($urandom_range(255));
                vv = CHAN_W'($urandom_range(255));
            end
            send_pixel(hv, sv, vv, p == len - 1);
        end
    endtask

    // One register setting followed by a few frames, well formed for the most part.
    task automatic random_phase();
        int unsigned w_cfg, h_cfg, w, h, n_frames, len, pick, n, k;
        pick = $urandom_range(99);
        if (pick < 70) begin
            w_cfg    = $urandom_range(8, 1);
            h_cfg    = $urandom_range(8, 1);
            n_frames = $urandom_range(10, 4);
        end else if (pick < 80) begin
            w_cfg    = $urandom_range(3, 2);
            h_cfg    = $urandom_range(90, 45);
            n_frames = $urandom_range(4, 2);
        end else if (pick < 90) begin
            w_cfg    = $urandom_range(90, 45);
            h_cfg    = $urandom_range(3, 1);
            n_frames = $urandom_range(4, 2);
        end else begin
            // Zero, small and oversized frame sizes.
            case ($urandom_range(2))
                0:       w_cfg = 0;
                1:       w_cfg = 1;
                default: w_cfg = $urandom_range(4095, 2048);
            endcase
            h_cfg    = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(4095, 2048);
            n_frames = $urandom_range(6, 3);
        end
        configure(pick_target(), pick_target(), pick_target(), pick_thr(), w_cfg, h_cfg);
        w = board.limit_dim(CFG_DIM_W'(w_cfg), MAX_WIDTH);
        h = board.limit_dim(CFG_DIM_W'(h_cfg), MAX_HEIGHT);
        set_idle(t_idle'(settings % 4));
        repeat (n_frames) begin
            pick = $urandom_range(99);
            if (pick < 76)
                len = w * h;
            else if (pick < 86)
                len = $urandom_range(w * h, 1);
            else if (pick < 96)
                len = w * h + $urandom_range(2 * w + 2, 1);
            else
                len = 0;
            if (len > 300)
                len = $urandom_range(300, 1);
            if (len != 0) begin
                send_frame(w, h, len);
            end else begin
                // Burst of random pixels with stray frame ends.
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++)
                    send_pixel(CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                               CHAN_W'($urandom_range(255)),
                               (k == n - 1) || ($urandom_range(1) == 1));
            end
        end
    endtask

    initial begin
        board = new();
        set_idle(IDLE_NONE);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 3 x 3 frame with exact-match thresholds: hits at (1,1) and (2,2), near
        // misses on single channels and plain misses elsewhere.
        configure(100, 150, 200, 0, 3, 3);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd99,  8'd150, 8'd200, 1'b0);
        send_pixel(8'd100, 8'd150, 8'd201, 1'b0);
        send_pixel(8'd100, 8'd150, 8'd200, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd100, 8'd151, 8'd200, 1'b0);
        send_pixel(8'd100, 8'd150, 8'd200, 1'b1);
        // Early frame end with the centroid on the top row, then a frame with no hits.
        send_pixel(8'd1,   8'd2,   8'd3,   1'b0);
        send_pixel(8'd100, 8'd150, 8'd200, 1'b0);
        send_pixel(8'd100, 8'd150, 8'd200, 1'b1);
        send_pixel(8'd7,   8'd7,   8'd7,   1'b0);
        send_pixel(8'd200, 8'd100, 8'd50,  1'b1);
        wait_results();

        // Zero frame size acts as 1 x 1; clipped colour bands at a threshold of 120.
        configure(255, 0, 128, 120, 0, 0);
        send_pixel(8'd255, 8'd0,   8'd128, 1'b0);
        send_pixel(8'd135, 8'd120, 8'd8,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd248, 1'b0);
        send_pixel(8'd134, 8'd0,   8'd128, 1'b0);
        send_pixel(8'd200, 8'd60,  8'd249, 1'b1);
        wait_results();

        rand_pixels = board.pixels;
        while (board.pixels < rand_pixels + 720) begin
            random_phase();
            wait_results();
        end

        repeat (100) @(negedge i_clk);
        board.close_out();
        $display("Covered %0d pixels in %0d frames (%0d blobs found) over %0d register settings.",
                 board.pixels, board.frames, board.finds, settings);
        if (board.errors == 0)
            $display("PASS color_blob_centroid_tracker");
        else
            $display("FAIL color_blob_centroid_tracker");
        $finish;
    end
endmodule
